[hw/rtl/hmac_sha256_engine_top_assert.svh]
// Assertion macros shared by the HMAC-SHA256 engine modules.
`ifndef HMAC_SHA256_ENGINE_TOP_ASSERT_SVH
`define HMAC_SHA256_ENGINE_TOP_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define HSE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define HSE_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[hw/rtl/hse_pkg.sv]
// Shared types, constants and SHA-256 functions of the HMAC engine.
`timescale 1ns / 1ps
package hse_pkg;

  localparam int BytesPerItemDef = 8;
  localparam logic [7:0] IPad = 8'h36;
  localparam logic [7:0] OPad = 8'h5c;
  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [31:0] OuterLenBits = 32'd768;
  localparam logic [63:0] KeyBlockBits = 64'd512;

  localparam logic [31:0] ShaIv [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_ROUND, ST_ADD, ST_ABSORB, ST_PAD, ST_FIN, ST_OUTB, ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    MODE_MSG, MODE_KEYIN, MODE_KEYOUT, MODE_OUTMSG
  } mode_e;

  typedef struct packed {
    logic [63:0] word;
    logic [1:0]  index;
    logic        done;
  } tag_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    logic [63:0] d;
    d = {x, x} >> n;
    return d[31:0];
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

[hw/rtl/hmac_sha256_engine_top.sv]
// Top level of the HMAC-SHA256 engine: key registers, input queue, core, result queue.
// Usage:
//   Load the 32-byte key through cfg_we_i/cfg_idx_i/cfg_data_i (index 0..3) while idle.
//   Push message items (up to eight bytes, first byte in the top bits) while full is low;
//   mark the final item with last_item_i. Pop four tag words, word 0 first, while
//   empty is low; tag_done_o marks word 3.
//   Timing: the core absorbs one byte per cycle while no compression runs; each item
//   goes through take, one absorb step per byte, and an end-of-item step.
//   Each SHA-256 compression runs load, 64 rounds and add in one shared
//   round unit. A message adds one compression for the key block up front, one per
//   64 message bytes, and at the end the padding bytes, one or two inner final
//   compressions, two outer compressions and the emit of the four tag words.
//   A two-item input queue lets the next item be pushed while the core works.
//   If the receiver stalls, the four-entry result queue holds the tag and the core
//   waits in its emit step; input items keep queueing until the input queue is full.
//   Reset empties both queues, clears the key to zero and arms the inner key block.
`timescale 1ns / 1ps
module hmac_sha256_engine_top #(
  parameter int BytesPerItem = hse_pkg::BytesPerItemDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [63:0]               cfg_data_i,
  input  logic                      push,
  output logic                      full,
  input  logic [8*BytesPerItem-1:0] data_bytes_i,
  input  logic [3:0]                byte_count_i,
  input  logic                      last_item_i,
  output logic                      empty,
  input  logic                      pop,
  output logic [63:0]               tag_word_o,
  output logic [1:0]                word_index_o,
  output logic                      tag_done_o
);

  logic [3:0][63:0] key_q;
  logic q_valid, q_pop, q_last, out_full, out_push;
  logic [8*BytesPerItem-1:0] q_data;
  logic [3:0] q_cnt;
  hse_pkg::tag_t out_item, head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_we_i) begin
      key_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  hse_front #(.BytesPerItem(BytesPerItem)) u_front (
    .clk_i, .rst_ni, .push, .full, .data_bytes_i, .byte_count_i, .last_item_i,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_data_o(q_data), .q_cnt_o(q_cnt),
    .q_last_o(q_last)
  );

  hse_core #(.BytesPerItem(BytesPerItem)) u_core (
    .clk_i, .rst_ni, .key_i(key_q), .q_valid_i(q_valid), .q_pop_o(q_pop),
    .q_data_i(q_data), .q_cnt_i(q_cnt), .q_last_i(q_last), .out_full_i(out_full),
    .out_push_o(out_push), .out_item_o(out_item)
  );

  hse_outq u_outq (
    .clk_i, .rst_ni, .push_i(out_push), .item_i(out_item), .full_o(out_full),
    .empty, .pop, .item_o(head)
  );

  assign tag_word_o = head.word;
  assign word_index_o = head.index;
  assign tag_done_o = head.done;

endmodule

[hw/rtl/hse_front.sv]
// Input side: takes items, clamps the byte count and queues them for the core.
`timescale 1ns / 1ps
module hse_front #(
  parameter int BytesPerItem = hse_pkg::BytesPerItemDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  logic [8*BytesPerItem-1:0] data_bytes_i,
  input  logic [3:0]              byte_count_i,
  input  logic                    last_item_i,
  output logic                    q_valid_o,
  input  logic                    q_pop_i,
  output logic [8*BytesPerItem-1:0] q_data_o,
  output logic [3:0]              q_cnt_o,
  output logic                    q_last_o
);

  logic [8*BytesPerItem-1:0] data_q [2];
  logic [3:0] cnt_q [2];
  logic       last_q [2];
  logic wr_q, wr_d, rd_q, rd_d;
  logic [1:0] num_q, num_d;
  logic wr_en;
  logic [3:0] cnt_clamp;

  assign full = (num_q == 2'd2);
  assign wr_en = push && !full;
  assign q_valid_o = (num_q != 2'd0);
  assign q_data_o = data_q[rd_q];
  assign q_cnt_o = cnt_q[rd_q];
  assign q_last_o = last_q[rd_q];
  // oversized counts mean a full item
  assign cnt_clamp = (byte_count_i > 4'(BytesPerItem)) ? 4'(BytesPerItem) : byte_count_i;

  always_comb begin
    wr_d = wr_en ? ~wr_q : wr_q;
    rd_d = q_pop_i ? ~rd_q : rd_q;
    num_d = num_q + {1'b0, wr_en} - {1'b0, q_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      num_q <= 2'd0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      num_q <= num_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      data_q[wr_q] <= data_bytes_i;
      cnt_q[wr_q] <= cnt_clamp;
      last_q[wr_q] <= last_item_i;
    end
  end

endmodule

[hw/rtl/hse_core.sv]
// Back end: absorbs bytes, pads, runs SHA-256 compressions and emits the tag.
`timescale 1ns / 1ps
module hse_core #(
  parameter int BytesPerItem = hse_pkg::BytesPerItemDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [3:0][63:0]          key_i,
  input  logic                      q_valid_i,
  output logic                      q_pop_o,
  input  logic [8*BytesPerItem-1:0] q_data_i,
  input  logic [3:0]                q_cnt_i,
  input  logic                      q_last_i,
  input  logic                      out_full_i,
  output logic                      out_push_o,
  output hse_pkg::tag_t             out_item_o
);

  localparam int DataW = 8 * BytesPerItem;

  hse_pkg::state_e state_q, state_d, ret_q, ret_d;
  hse_pkg::mode_e  mode_q, mode_d;
  logic [5:0]  t_q, t_d;
  logic [31:0] h_q [8];
  logic [31:0] h_d [8];
  logic [31:0] v_q [8];
  logic [31:0] v_d [8];
  logic [31:0] w_q [16];
  logic [31:0] w_d [16];
  logic [31:0] buf_q [16];
  logic [31:0] buf_d [16];
  logic [31:0] dig_q [8];
  logic [31:0] dig_d [8];
  logic [5:0]  fill_q, fill_d;
  logic [63:0] len_q, len_d;
  logic        phase_q, phase_d;
  logic [DataW-1:0] data_q, data_d;
  logic [3:0]  cnt_q, cnt_d, idx_q, idx_d;
  logic        last_q, last_d;
  logic        first_q, first_d, lenok_q, lenok_d;
  logic [1:0]  e_q, e_d;

  logic [31:0] kw32, pad32, wsel, wsch, wcur, t1, t2;
  logic [63:0] kw, bits, lsh;
  logic [DataW-1:0] dsh;
  logic [7:0]  pbyte, bbyte, wbyte;
  logic        wr_byte, lenok_eff;

  // message word for the first sixteen rounds
  always_comb begin
    kw = key_i[t_q[2:1]];
    kw32 = t_q[0] ? kw[31:0] : kw[63:32];
    pad32 = (mode_q == hse_pkg::MODE_KEYIN) ? {4{hse_pkg::IPad}} : {4{hse_pkg::OPad}};
    case (mode_q)
      hse_pkg::MODE_MSG: wsel = buf_q[t_q[3:0]];
      hse_pkg::MODE_KEYIN, hse_pkg::MODE_KEYOUT: wsel = (t_q < 6'd8) ? (kw32 ^ pad32) : pad32;
      hse_pkg::MODE_OUTMSG: begin
        if (t_q < 6'd8) wsel = dig_q[t_q[2:0]];
        else if (t_q == 6'd8) wsel = {hse_pkg::PadMark, 24'd0};
        else if (t_q == 6'd15) wsel = hse_pkg::OuterLenBits;
        else wsel = 32'd0;
      end
      default: wsel = 32'd0;
    endcase
    wsch = w_q[0] + hse_pkg::ssig0(w_q[1]) + w_q[9] + hse_pkg::ssig1(w_q[14]);
    wcur = (t_q < 6'd16) ? wsel : wsch;
    t1 = v_q[7] + hse_pkg::bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
       + hse_pkg::RoundK[t_q] + wcur;
    t2 = hse_pkg::bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  // byte sources for absorb and padding
  always_comb begin
    dsh = data_q << {idx_q, 3'b000};
    bbyte = dsh[DataW-1 -: 8];
    bits = {len_q[60:0], 3'b000} + hse_pkg::KeyBlockBits;
    lsh = bits << {fill_q[2:0], 3'b000};
    if (first_q) pbyte = hse_pkg::PadMark;
    else if (fill_q >= 6'd56 && lenok_q) pbyte = lsh[63:56];
    else pbyte = 8'd0;
    lenok_eff = first_q ? (fill_q < 6'd56) : lenok_q;
  end

  always_comb begin
    state_d = state_q;
    ret_d = ret_q;
    mode_d = mode_q;
    t_d = t_q;
    h_d = h_q;
    v_d = v_q;
    w_d = w_q;
    buf_d = buf_q;
    dig_d = dig_q;
    fill_d = fill_q;
    len_d = len_q;
    phase_d = phase_q;
    data_d = data_q;
    cnt_d = cnt_q;
    idx_d = idx_q;
    last_d = last_q;
    first_d = first_q;
    lenok_d = lenok_q;
    e_d = e_q;
    q_pop_o = 1'b0;
    out_push_o = 1'b0;
    wr_byte = 1'b0;
    wbyte = bbyte;
    out_item_o.word = {h_q[{e_q, 1'b0}], h_q[{e_q, 1'b1}]};
    out_item_o.index = e_q;
    out_item_o.done = (e_q == 2'd3);
    case (state_q)
      hse_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          data_d = q_data_i;
          cnt_d = q_cnt_i;
          last_d = q_last_i;
          idx_d = 4'd0;
          if (!phase_q) begin
            // start a message with the inner key block
            phase_d = 1'b1;
            h_d = hse_pkg::ShaIv;
            fill_d = 6'd0;
            len_d = 64'd0;
            mode_d = hse_pkg::MODE_KEYIN;
            ret_d = hse_pkg::ST_ABSORB;
            state_d = hse_pkg::ST_LOAD;
          end else begin
            state_d = hse_pkg::ST_ABSORB;
          end
        end
      end
      hse_pkg::ST_LOAD: begin
        v_d = h_q;
        t_d = 6'd0;
        state_d = hse_pkg::ST_ROUND;
      end
      hse_pkg::ST_ROUND: begin
        for (int i = 0; i < 15; i++) w_d[i] = w_q[i+1];
        w_d[15] = wcur;
        v_d[7] = v_q[6];
        v_d[6] = v_q[5];
        v_d[5] = v_q[4];
        v_d[4] = v_q[3] + t1;
        v_d[3] = v_q[2];
        v_d[2] = v_q[1];
        v_d[1] = v_q[0];
        v_d[0] = t1 + t2;
        t_d = t_q + 6'd1;
        if (t_q == 6'd63) state_d = hse_pkg::ST_ADD;
      end
      hse_pkg::ST_ADD: begin
        for (int i = 0; i < 8; i++) h_d[i] = h_q[i] + v_q[i];
        state_d = ret_q;
      end
      hse_pkg::ST_ABSORB: begin
        if (idx_q < cnt_q) begin
          wr_byte = 1'b1;
          fill_d = fill_q + 6'd1;
          len_d = len_q + 64'd1;
          idx_d = idx_q + 4'd1;
          if (fill_q == 6'd63) begin
            mode_d = hse_pkg::MODE_MSG;
            ret_d = hse_pkg::ST_ABSORB;
            state_d = hse_pkg::ST_LOAD;
          end
        end else if (last_q) begin
          first_d = 1'b1;
          state_d = hse_pkg::ST_PAD;
        end else begin
          state_d = hse_pkg::ST_IDLE;
        end
      end
      hse_pkg::ST_PAD: begin
        wr_byte = 1'b1;
        wbyte = pbyte;
        first_d = 1'b0;
        lenok_d = lenok_eff;
        fill_d = fill_q + 6'd1;
        if (fill_q == 6'd63) begin
          mode_d = hse_pkg::MODE_MSG;
          state_d = hse_pkg::ST_LOAD;
          if (lenok_eff) begin
            ret_d = hse_pkg::ST_FIN;
          end else begin
            // length goes into a second block
            ret_d = hse_pkg::ST_PAD;
            lenok_d = 1'b1;
          end
        end
      end
      hse_pkg::ST_FIN: begin
        dig_d = h_q;
        h_d = hse_pkg::ShaIv;
        mode_d = hse_pkg::MODE_KEYOUT;
        ret_d = hse_pkg::ST_OUTB;
        state_d = hse_pkg::ST_LOAD;
      end
      hse_pkg::ST_OUTB: begin
        mode_d = hse_pkg::MODE_OUTMSG;
        ret_d = hse_pkg::ST_EMIT;
        state_d = hse_pkg::ST_LOAD;
      end
      hse_pkg::ST_EMIT: begin
        if (!out_full_i) begin
          out_push_o = 1'b1;
          e_d = e_q + 2'd1;
          if (e_q == 2'd3) begin
            phase_d = 1'b0;
            fill_d = 6'd0;
            len_d = 64'd0;
            state_d = hse_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = hse_pkg::ST_IDLE;
    endcase
    if (wr_byte) buf_d[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] = wbyte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hse_pkg::ST_IDLE;
      ret_q <= hse_pkg::ST_IDLE;
      mode_q <= hse_pkg::MODE_MSG;
      t_q <= 6'd0;
      h_q <= hse_pkg::ShaIv;
      fill_q <= 6'd0;
      len_q <= 64'd0;
      phase_q <= 1'b0;
      idx_q <= 4'd0;
      cnt_q <= 4'd0;
      last_q <= 1'b0;
      first_q <= 1'b0;
      lenok_q <= 1'b0;
      e_q <= 2'd0;
    end else begin
      state_q <= state_d;
      ret_q <= ret_d;
      mode_q <= mode_d;
      t_q <= t_d;
      h_q <= h_d;
      fill_q <= fill_d;
      len_q <= len_d;
      phase_q <= phase_d;
      idx_q <= idx_d;
      cnt_q <= cnt_d;
      last_q <= last_d;
      first_q <= first_d;
      lenok_q <= lenok_d;
      e_q <= e_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    w_q <= w_d;
    buf_q <= buf_d;
    dig_q <= dig_d;
    data_q <= data_d;
  end

`include "hmac_sha256_engine_top_assert.svh"

  `HSE_ASSERT(a_round_step, (state_q == hse_pkg::ST_ROUND && t_q != 6'd63) |=> (t_q == $past(t_q) + 6'd1), "round counter skipped")
  `HSE_ASSERT_NEVER(a_pop_busy, q_pop_o && state_q != hse_pkg::ST_IDLE, "item taken while busy")
  `HSE_ASSERT_NEVER(a_push_state, out_push_o && state_q != hse_pkg::ST_EMIT, "tag word outside emit")
  `HSE_ASSERT(a_round_end, (state_q == hse_pkg::ST_ROUND && t_q == 6'd63) |=> (state_q == hse_pkg::ST_ADD), "compression did not finish")

endmodule

[hw/rtl/hse_outq.sv]
// Four-entry result queue holding tag words until they are popped.
`timescale 1ns / 1ps
module hse_outq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hse_pkg::tag_t item_i,
  output logic          full_o,
  output logic          empty,
  input  logic          pop,
  output hse_pkg::tag_t item_o
);

  hse_pkg::tag_t mem_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] num_q, num_d;
  logic do_pop;

  assign full_o = (num_q == 3'd4);
  assign empty = (num_q == 3'd0);
  assign do_pop = pop && !empty;
  assign item_o = mem_q[rd_q];

  always_comb begin
    num_d = num_q + {2'b00, push_i} - {2'b00, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 2'd0;
      rd_q <= 2'd0;
      num_q <= 3'd0;
    end else begin
      if (push_i) wr_q <= wr_q + 2'd1;
      if (do_pop) rd_q <= rd_q + 2'd1;
      num_q <= num_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

endmodule
